// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the key-value text lexer.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define KVL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the next cycle, outside reset.
`define KVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kvlex_pkg.sv -----
`timescale 1ns / 1ps
// Package for the key-value text lexer: lexer modes, event kinds, event record,
// character codes and queue sizing. No dependencies.
package kvlex_pkg;

  localparam int unsigned EVQ_DEPTH  = 8;
  localparam int unsigned MAX_EVENTS = 3;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_QUOTED  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_BARE    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    EV_LBRACE = 2'd0,
    EV_RBRACE = 2'd1,
    EV_CHAR   = 2'd2,
    EV_END    = 2'd3
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] chr;
    logic       last;
  } ev_t;

endpackage

// ----- rtl/kvlex_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the key-value text lexer: one text byte per request.
// No dependencies.
interface kvlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// ----- rtl/kvlex_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the key-value text lexer: one token event per request.
// No dependencies.
interface kvlex_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] char_value;
  logic       run_last;

  modport source (output valid, output event_kind, output char_value, output run_last,
                  input ready);
  modport sink   (input valid, input event_kind, input char_value, input run_last,
                  output ready);
endinterface

// ----- rtl/keyvalue_text_lexer.sv -----
`timescale 1ns / 1ps
// Key-value text lexer top level: byte decode, lexer mode register, event queue.
// Depends on kvlex_pkg, kvlex_in_if, kvlex_out_if and assert_macros.svh.

// One text byte is taken per cycle whenever the event queue has room for three
// more events; the byte is decoded in the same cycle and its zero to three
// token events go into the queue at once, so back-to-back bytes are lexed with
// no bubbles. The queue (EVQ_DEPTH entries, default 8) drains one event per
// cycle through the result port while it is ready, so the sustained rate is
// one byte per cycle while bytes average at most one event each; bursts of
// braces around short strings are soaked up by the queue and throttle input
// only when it nears full. A byte's events are written to the queue registers.
`include "assert_macros.svh"

module keyvalue_text_lexer #(
  parameter int unsigned EVQ_DEPTH = kvlex_pkg::EVQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  kvlex_in_if.sink    in_chan,
  kvlex_out_if.source out_chan
);
  import kvlex_pkg::*;

  localparam int unsigned PTR_W = $clog2(EVQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(EVQ_DEPTH + 1);
  localparam int unsigned NEV_W = $clog2(MAX_EVENTS + 1);
  localparam int unsigned NCAND = 5;
  localparam logic [CNT_W-1:0] FILL_LIMIT = CNT_W'(EVQ_DEPTH - MAX_EVENTS);

  // ---------------------------------------------------------------- decode
  logic [7:0] b;
  logic       fin;
  logic       in_acc;
  logic       is_sp;
  logic       is_delim;
  logic       slash_pend;
  logic       in_bare;
  logic       bare_end;
  logic       mode_is_idle;

  mode_t      mode_r, mode_nxt, mode_step, idle_mode;

  assign b      = in_chan.text_byte;
  assign fin    = in_chan.final_byte;
  assign in_acc = in_chan.valid & in_chan.ready;

  assign is_sp    = b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  assign is_delim = is_sp | (b inside {CH_LBRACE, CH_RBRACE, CH_QUOTE});

  // unused mode codes behave as idle
  assign mode_is_idle = !(mode_r inside {MODE_SLASH, MODE_COMMENT, MODE_QUOTED,
                                          MODE_ESCAPE, MODE_BARE});

  // a lone slash turns into the first character of a bare token
  assign slash_pend = (mode_r == MODE_SLASH) && (b != CH_SLASH);
  assign in_bare    = (mode_r == MODE_BARE) || slash_pend;
  assign bare_end   = in_bare && is_delim;

  // ---------------------------------------------------------------- next mode
  always_comb begin
    if (is_sp) begin
      idle_mode = MODE_IDLE;
    end else if (b == CH_SLASH) begin
      idle_mode = MODE_SLASH;
    end else if (b == CH_QUOTE) begin
      idle_mode = MODE_QUOTED;
    end else if (b == CH_LBRACE || b == CH_RBRACE) begin
      idle_mode = MODE_IDLE;
    end else begin
      idle_mode = MODE_BARE;
    end

    case (mode_r)
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode_step = MODE_COMMENT;
        end else begin
          mode_step = bare_end ? idle_mode : MODE_BARE;
        end
      end
      MODE_BARE: begin
        mode_step = bare_end ? idle_mode : MODE_BARE;
      end
      MODE_COMMENT: begin
        mode_step = (b == CH_LF) ? MODE_IDLE : MODE_COMMENT;
      end
      MODE_QUOTED: begin
        if (b == CH_QUOTE) begin
          mode_step = MODE_IDLE;
        end else if (b == CH_BSLASH && !fin) begin
          mode_step = MODE_ESCAPE;
        end else begin
          mode_step = MODE_QUOTED;
        end
      end
      MODE_ESCAPE: begin
        mode_step = MODE_QUOTED;
      end
      default: begin
        mode_step = idle_mode;
      end
    endcase

    mode_nxt = fin ? MODE_IDLE : mode_step;
  end

  // ---------------------------------------------------------------- events
  ev_t              cand [NCAND];
  logic [NCAND-1:0] cand_en;
  ev_t              idle_ev;
  logic             idle_en;
  ev_t              slot [MAX_EVENTS];
  logic [NEV_W-1:0] n_ev;

  always_comb begin
    idle_en = !is_sp && (b != CH_SLASH) && (b != CH_QUOTE);
    if (b == CH_LBRACE) begin
      idle_ev = '{kind: EV_LBRACE, chr: 8'h00, last: 1'b0};
    end else if (b == CH_RBRACE) begin
      idle_ev = '{kind: EV_RBRACE, chr: 8'h00, last: 1'b0};
    end else begin
      idle_ev = '{kind: EV_CHAR, chr: b, last: 1'b0};
    end

    // candidate order follows the order events leave the lexer
    cand_en[0] = slash_pend;
    cand[0]    = '{kind: EV_CHAR, chr: CH_SLASH, last: 1'b0};

    cand_en[1] = 1'b0;
    cand[1]    = '{kind: EV_CHAR, chr: b, last: 1'b0};
    case (mode_r)
      MODE_QUOTED: begin
        if (b == CH_QUOTE) begin
          cand_en[1] = 1'b1;
          cand[1]    = '{kind: EV_END, chr: 8'h00, last: 1'b0};
        end else if (b == CH_BSLASH) begin
          // trailing backslash is kept literally
          cand_en[1] = fin;
        end else begin
          cand_en[1] = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        cand_en[1] = 1'b1;
        if (b == CH_LOW_N) begin
          cand[1].chr = CH_LF;
        end else if (b == CH_LOW_T) begin
          cand[1].chr = CH_TAB;
        end
      end
      MODE_COMMENT: begin
        cand_en[1] = 1'b0;
      end
      default: begin
        if (in_bare) begin
          cand_en[1] = 1'b1;
          if (is_delim) begin
            cand[1] = '{kind: EV_END, chr: 8'h00, last: 1'b0};
          end
        end else if (mode_is_idle) begin
          cand_en[1] = idle_en;
          cand[1]    = idle_ev;
        end
      end
    endcase

    // delimiter that closed a bare token is lexed again from idle
    cand_en[2] = bare_end && idle_en;
    cand[2]    = idle_ev;

    cand_en[3] = fin && (mode_step == MODE_QUOTED || mode_step == MODE_BARE ||
                         mode_step == MODE_SLASH);
    if (mode_step == MODE_SLASH) begin
      cand[3] = '{kind: EV_CHAR, chr: CH_SLASH, last: 1'b0};
    end else begin
      cand[3] = '{kind: EV_END, chr: 8'h00, last: 1'b0};
    end

    cand_en[4] = fin && (mode_step == MODE_SLASH);
    cand[4]    = '{kind: EV_END, chr: 8'h00, last: 1'b0};

    n_ev = '0;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      slot[i] = '{kind: EV_LBRACE, chr: 8'h00, last: 1'b0};
    end
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && n_ev != NEV_W'(MAX_EVENTS)) begin
        slot[n_ev] = cand[i];
        n_ev       = n_ev + NEV_W'(1);
      end
    end
    if (n_ev != '0) begin
      slot[n_ev - NEV_W'(1)].last = 1'b1;
    end
  end

  // ---------------------------------------------------------------- event queue
  ev_t              q_r [EVQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_idx [MAX_EVENTS];
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W:0]   k);
    logic [PTR_W:0] s;
    s = {1'b0, p} + k;
    if (s >= (PTR_W + 1)'(EVQ_DEPTH)) begin
      s = s - (PTR_W + 1)'(EVQ_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign in_chan.ready = (count_r <= FILL_LIMIT);
  assign pop           = out_chan.valid & out_chan.ready;

  always_comb begin
    for (int j = 0; j < MAX_EVENTS; j++) begin
      wr_idx[j] = ptr_add(wr_ptr_r, (PTR_W + 1)'(j));
    end
    wr_ptr_nxt = in_acc ? ptr_add(wr_ptr_r, (PTR_W + 1)'(n_ev)) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_add(rd_ptr_r, (PTR_W + 1)'(1)) : rd_ptr_r;
    count_nxt  = count_r + (in_acc ? CNT_W'(n_ev) : '0) - (pop ? CNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_EVENTS; j++) begin
      if (in_acc && NEV_W'(j) < n_ev) begin
        q_r[wr_idx[j]] <= slot[j];
      end
    end
  end

  assign out_chan.valid      = (count_r != '0);
  assign out_chan.event_kind = q_r[rd_ptr_r].kind;
  assign out_chan.char_value = q_r[rd_ptr_r].chr;
  assign out_chan.run_last   = q_r[rd_ptr_r].last;

  // ---------------------------------------------------------------- checks
  `KVL_ASSERT(a_count_bound, count_r <= CNT_W'(EVQ_DEPTH), "event queue overfilled")
  `KVL_ASSERT(a_empty_ptrs, (count_r != '0) || (wr_ptr_r == rd_ptr_r), "empty queue with pointer gap")
  `KVL_ASSERT_NEXT(a_final_idle, in_acc && fin, mode_r == MODE_IDLE, "mode not idle after final byte")
  `KVL_ASSERT_NEXT(a_escape_src, in_acc && mode_nxt == MODE_ESCAPE, $past(mode_r) == MODE_QUOTED, "escape entered outside a quoted string")

endmodule

// ----- tb/keyvalue_text_lexer_tb.sv -----
`timescale 1ns / 1ps
// Testbench for keyvalue_text_lexer: directed and random texts, with token events
// predicted in a scoreboard class and checked in order, field by field.
// Depends on kvlex_pkg, kvlex_in_if, kvlex_out_if and the keyvalue_text_lexer RTL.
module keyvalue_text_lexer_tb;
  import kvlex_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned TEXT_BYTES   = 460;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_PRINTS   = 40;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } text_req_t;

  // Predicts the token events of each accepted request and checks results against them.
  class lexer_scoreboard;
    mode_t       mode = MODE_IDLE;
    ev_t         pending[$];
    ev_t         fresh[$];
    int unsigned mismatches = 0;
    int unsigned events_seen = 0;

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH: %s", msg);
    endtask

    function bit is_blank(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function void add_event(ev_kind_t k, logic [7:0] c);
      ev_t e;
      if (fresh.size() >= MAX_EVENTS) return;
      e.kind = k;
      e.chr  = (k == EV_CHAR) ? c : 8'h00;
      e.last = 1'b0;
      fresh = {fresh, e};
    endfunction

    function void lex_between(logic [7:0] b);
      mode = MODE_IDLE;
      if (is_blank(b)) return;
      if (b == CH_SLASH) begin
        mode = MODE_SLASH;
      end else if (b == CH_LBRACE) begin
        add_event(EV_LBRACE, 8'h00);
      end else if (b == CH_RBRACE) begin
        add_event(EV_RBRACE, 8'h00);
      end else if (b == CH_QUOTE) begin
        mode = MODE_QUOTED;
      end else begin
        add_event(EV_CHAR, b);
        mode = MODE_BARE;
      end
    endfunction

    // A bare word ends before a blank, a brace or a quote; that byte is then lexed afresh.
    function void lex_word(logic [7:0] b);
      if (is_blank(b) || b == CH_LBRACE || b == CH_RBRACE || b == CH_QUOTE) begin
        add_event(EV_END, 8'h00);
        lex_between(b);
      end else begin
        add_event(EV_CHAR, b);
      end
    endfunction

    function void note_request(logic [7:0] b, logic fin);
      fresh.delete();
      case (mode)
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            mode = MODE_COMMENT;
          end else begin
            add_event(EV_CHAR, CH_SLASH);
            mode = MODE_BARE;
            lex_word(b);
          end
        end
        MODE_COMMENT: begin
          if (b == CH_LF) mode = MODE_IDLE;
        end
        MODE_QUOTED: begin
          if (b == CH_QUOTE) begin
            add_event(EV_END, 8'h00);
            mode = MODE_IDLE;
          end else if (b == CH_BSLASH) begin
            // trailing backslash is kept as it stands
            if (fin) add_event(EV_CHAR, CH_BSLASH);
            else mode = MODE_ESCAPE;
          end else begin
            add_event(EV_CHAR, b);
          end
        end
        MODE_ESCAPE: begin
          add_event(EV_CHAR, (b == CH_LOW_N) ? CH_LF : (b == CH_LOW_T) ? CH_TAB : b);
          mode = MODE_QUOTED;
        end
        MODE_BARE: lex_word(b);
        default: lex_between(b);
      endcase
      if (fin) begin
        if (mode == MODE_QUOTED || mode == MODE_BARE) begin
          add_event(EV_END, 8'h00);
        end else if (mode == MODE_SLASH) begin
          add_event(EV_CHAR, CH_SLASH);
          add_event(EV_END, 8'h00);
        end
        mode = MODE_IDLE;
      end
      if (fresh.size() > 0) begin
        fresh[fresh.size() - 1].last = 1'b1;
      end
      pending = {pending, fresh};
    endfunction

    task check_event(logic [1:0] k, logic [7:0] c, logic l);
      ev_t want;
      events_seen++;
      if (pending.size() == 0) begin
        report($sformatf("event kind %0d char %02h last %0d with none expected", k, c, l));
        return;
      end
      want = pending.pop_front();
      if (k !== want.kind)
        report($sformatf("event %0d: kind %0d, wanted %0d", events_seen, k, want.kind));
      if (c !== want.chr)
        report($sformatf("event %0d: char %02h, wanted %02h", events_seen, c, want.chr));
      if (l !== want.last)
        report($sformatf("event %0d: last %0d, wanted %0d", events_seen, l, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  kvlex_in_if  in_chan();
  kvlex_out_if out_chan();

  keyvalue_text_lexer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  lexer_scoreboard sb = new();

  text_req_t   text_reqs[$];
  int unsigned text_count = 0;
  int unsigned accepted_bytes = 0;
  int unsigned cycle_count = 0;
  logic        hold_off = 1'b0;

  always #10 clk = ~clk;

  // ---- text building ----
  function automatic void put(logic [7:0] b);
    text_req_t r;
    r.b   = b;
    r.fin = 1'b0;
    text_reqs = {text_reqs, r};
  endfunction

  function automatic void end_text();
    text_reqs[text_reqs.size() - 1].fin = 1'b1;
    text_count++;
  endfunction

  function automatic void put_string(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic void add_random_text();
    int unsigned n_tok, pick, len;
    logic [7:0]  b;
    n_tok = $urandom_range(1, 10);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        put($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
      end else if (pick < 30) begin
        case ($urandom_range(0, 3))
          0: put(CH_SPACE);
          1: put(CH_TAB);
          2: put(CH_CR);
          default: put(CH_LF);
        endcase
      end else if (pick < 55) begin
        put(CH_QUOTE);
        len = $urandom_range(0, 6);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) begin
            put(CH_BSLASH);
            case ($urandom_range(0, 4))
              0: put(CH_LOW_N);
              1: put(CH_LOW_T);
              2: put(CH_QUOTE);
              3: put(CH_BSLASH);
              default: put(8'($urandom_range(0, 255)));
            endcase
          end else begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h7A;
            put(b);
          end
        end
        // now and then leave the string open
        if ($urandom_range(0, 9) != 0) put(CH_QUOTE);
      end else if (pick < 75) begin
        len = $urandom_range(1, 5);
        repeat (len) put(word_byte());
      end else if (pick < 83) begin
        put(CH_SLASH);
        put(CH_SLASH);
        len = $urandom_range(0, 5);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          put((b == CH_LF) ? 8'h78 : b);
        end
        if ($urandom_range(0, 9) != 0) put(CH_LF);
      end else if (pick < 90) begin
        put(CH_SLASH);
        put($urandom_range(0, 3) == 0 ? CH_LBRACE : word_byte());
      end else begin
        put(8'($urandom_range(0, 255)));
      end
    end
    end_text();
  endfunction

  // ---- sender ----
  task automatic send_request(text_req_t r);
    logic took;
    in_chan.valid      <= 1'b1;
    in_chan.text_byte  <= r.b;
    in_chan.final_byte <= r.fin;
    do begin
      @(negedge clk);
      took = in_chan.ready;
      @(posedge clk);
    end while (!took);
  endtask

  initial begin
    int unsigned idx, burst, gap;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.text_byte  <= 8'h00;
    in_chan.final_byte <= 1'b0;

    // braces, escapes n, t and other, a string closed by its quote
    put_string("{\"\\n\\t\\q\"}");
    end_text();
    // comment up to LF, slash then brace, bare word ended by TAB, CR at the end
    put_string("//c\n/{ b\t");
    put(CH_CR);
    end_text();
    // bare word cut by a quote that is also the final byte
    put_string("x\"");
    end_text();
    // backslash as the final byte of a string
    put_string("\"\\");
    end_text();
    // lone slash at end of text
    put(CH_SLASH);
    end_text();
    // comment still open at end of text
    put_string("//");
    end_text();
    put(8'h00);
    put(8'hFF);
    end_text();

    while (text_reqs.size() < TEXT_BYTES) add_random_text();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    while (idx < text_reqs.size()) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < burst && idx < text_reqs.size(); i++) begin
        send_request(text_reqs[idx]);
        idx++;
      end
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Lexed %0d bytes over %0d texts and checked %0d token events.",
             accepted_bytes, text_count, sb.events_seen);
    $display("Result port was held off for %0d cycles once to back the queue up.",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("keyvalue_text_lexer test passed");
    end else begin
      $display("keyvalue_text_lexer test failed");
    end
    $finish;
  end

  // ---- receiver: changing stall styles ----
  int unsigned rx_style = 0;
  int unsigned rx_left = 0;
  logic [3:0]  rx_phase = 4'd0;

  always @(posedge clk) begin
    rx_phase <= rx_phase + 4'd1;
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 3);
      rx_left  <= $urandom_range(20, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    if (!rst_n || hold_off) begin
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_style)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        2: out_chan.ready <= rx_phase[1];
        default: out_chan.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // long hold-off while the sender keeps offering bytes
  initial begin
    do @(posedge clk); while (accepted_bytes < HOLD_AFTER);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---- monitor: signals are stable at the falling edge ----
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request(in_chan.text_byte, in_chan.final_byte);
        accepted_bytes++;
      end
      if (out_chan.valid && out_chan.ready)
        sb.check_event(out_chan.event_kind, out_chan.char_value, out_chan.run_last);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d events outstanding.",
             cycle_count, sb.pending.size());
    $display("keyvalue_text_lexer test failed");
    $finish;
  end

endmodule
